/* hw/rtl/dbs_pkg.sv */
`timescale 1ns / 1ps

package dbs_pkg;

	localparam logic [2:0] ACT_LOAD_TRANS  = 3'd0;
	localparam logic [2:0] ACT_LOAD_ACCEPT = 3'd1;
	localparam logic [2:0] ACT_SCAN        = 3'd2;
	localparam logic [2:0] ACT_READ        = 3'd3;
	localparam logic [2:0] ACT_START       = 3'd4;

	localparam logic [2:0] KIND_LOAD_TRANS  = 3'd0;
	localparam logic [2:0] KIND_LOAD_ACCEPT = 3'd1;
	localparam logic [2:0] KIND_SCAN        = 3'd2;
	localparam logic [2:0] KIND_READ        = 3'd3;
	localparam logic [2:0] KIND_START       = 3'd4;
	localparam logic [2:0] KIND_NOP         = 3'd5;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [2:0]  kind;
		logic        idx_ok;
		logic        tgt_ok;
		logic [9:0]  state_index;
		logic [7:0]  symbol;
		logic [9:0]  target_state;
		logic [31:0] rule_mask;
	} cmd_t;

endpackage

/* hw/rtl/dbs_front.sv */
`timescale 1ns / 1ps

module dbs_front import dbs_pkg::*; #(
	parameter int STATE_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [9:0]  state_index,
	input  logic [7:0]  symbol,
	input  logic [9:0]  target_state,
	input  logic [31:0] rule_mask,
	input  logic        clearing,
	output logic        push_valid,
	input  logic        push_ready,
	output cmd_t        push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_d;

	assign in_ready   = (!valid_s1 || push_ready) && !clearing;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_comb begin
		cmd_d.state_index  = state_index;
		cmd_d.symbol       = symbol;
		cmd_d.target_state = target_state;
		cmd_d.rule_mask    = rule_mask;
		cmd_d.idx_ok       = 32'(state_index) < 32'(STATE_COUNT);
		cmd_d.tgt_ok       = 32'(target_state) < 32'(STATE_COUNT);
		case (action)
			ACT_LOAD_TRANS: cmd_d.kind = KIND_LOAD_TRANS;
			ACT_LOAD_ACCEPT: cmd_d.kind = KIND_LOAD_ACCEPT;
			ACT_SCAN: cmd_d.kind = KIND_SCAN;
			ACT_READ: cmd_d.kind = KIND_READ;
			ACT_START: cmd_d.kind = KIND_START;
			default: cmd_d.kind = KIND_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* hw/rtl/dbs_queue.sv */
`timescale 1ns / 1ps

module dbs_queue import dbs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t            entry_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != Q_CW'(Q_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* hw/rtl/dbs_back.sv */
`timescale 1ns / 1ps

module dbs_back import dbs_pkg::*; #(
	parameter int STATE_COUNT = 1024,
	parameter int RULE_COUNT  = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  cmd_t        pop_cmd,
	output logic        clearing,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  current_state,
	output logic        accept_hit,
	output logic [31:0] rules_here,
	output logic [31:0] rules_matched,
	output logic [31:0] visit_count,
	output logic [31:0] bytes_seen
);

	localparam int SB  = $clog2(STATE_COUNT);
	localparam int SW  = (SB > 10) ? SB : 10;
	localparam int RW  = (RULE_COUNT > 32) ? RULE_COUNT : 32;
	localparam int VW  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam int TD  = STATE_COUNT * 256;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN_T = 3'd1;
	localparam logic [2:0] ST_SCAN_V = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;

	logic [SB-1:0]         trans_mem [TD];
	logic [RULE_COUNT-1:0] acc_mem [STATE_COUNT];
	logic [COUNT_BITS-1:0] vis_mem [STATE_COUNT];

	logic [2:0]            state_q;
	logic [2:0]            cur_kind_q;
	logic                  cur_idx_ok_q;
	logic [SB-1:0]         ps_q;
	logic [RULE_COUNT-1:0] union_q;
	logic [31:0]           bytes_q;
	logic [SB-1:0]         nxt_q;
	logic [SB-1:0]         clr_addr_q;
	logic                  clr_one_q;
	logic [SB-1:0]         trans_rd_q;
	logic [RULE_COUNT-1:0] acc_rd_q;
	logic [COUNT_BITS-1:0] vis_rd_q;
	logic                  out_valid_q;
	logic [9:0]            cur_state_q;
	logic                  hit_q;
	logic [31:0]           here_q;
	logic [31:0]           matched_q;
	logic [31:0]           visits_q;
	logic [31:0]           bytes_out_q;

	logic                  pop;
	logic                  slot_free;
	logic                  commit;
	logic [SB-1:0]         nxt_d;
	logic                  trans_we;
	logic                  trans_re;
	logic [SB+7:0]         trans_waddr;
	logic [SB+7:0]         trans_raddr;
	logic                  acc_we;
	logic                  acc_re;
	logic                  vis_we;
	logic                  vis_re;
	logic [SB-1:0]         vis_waddr;
	logic [SB-1:0]         vis_raddr;
	logic [COUNT_BITS-1:0] vis_wdata;
	logic [COUNT_BITS-1:0] vis_new;
	logic [31:0]           bytes_inc;
	logic [SB-1:0]         res_state;
	logic                  res_hit;
	logic [RULE_COUNT-1:0] res_here;
	logic [RULE_COUNT-1:0] res_matched;
	logic [VW-1:0]         res_visits;
	logic [31:0]           res_bytes;
	logic [SW-1:0]         state_w;
	logic [RW-1:0]         here_w;
	logic [RW-1:0]         matched_w;

	assign pop_ready = state_q == ST_IDLE;
	assign pop       = pop_valid && pop_ready;
	assign clearing  = state_q == ST_CLEAR;
	assign slot_free = !out_valid_q || out_ready;
	assign commit    = slot_free && (state_q == ST_SCAN_V || state_q == ST_READ ||
		state_q == ST_DONE);

	assign nxt_d     = (32'(trans_rd_q) >= 32'(STATE_COUNT)) ? '0 : trans_rd_q;
	assign vis_new   = (vis_rd_q == '1) ? vis_rd_q : vis_rd_q + 1'b1;
	assign bytes_inc = (bytes_q == '1) ? bytes_q : bytes_q + 32'd1;

	assign trans_we    = pop && pop_cmd.kind == KIND_LOAD_TRANS && pop_cmd.idx_ok &&
		pop_cmd.tgt_ok;
	assign trans_waddr = {SB'(pop_cmd.state_index), pop_cmd.symbol};
	assign trans_re    = pop && pop_cmd.kind == KIND_SCAN;
	assign trans_raddr = {ps_q, pop_cmd.symbol};
	assign acc_we      = pop && pop_cmd.kind == KIND_LOAD_ACCEPT && pop_cmd.idx_ok;
	assign acc_re      = state_q == ST_SCAN_T;
	assign vis_re      = (pop && pop_cmd.kind == KIND_READ) || state_q == ST_SCAN_T;
	assign vis_raddr   = (state_q == ST_SCAN_T) ? nxt_d : SB'(pop_cmd.state_index);
	assign vis_we      = (state_q == ST_SCAN_V && slot_free) || state_q == ST_CLEAR;
	assign vis_waddr   = (state_q == ST_CLEAR) ? clr_addr_q : nxt_q;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			vis_wdata = (clr_one_q && clr_addr_q == '0) ? COUNT_BITS'(1) : '0;
		end else begin
			vis_wdata = vis_new;
		end
	end

	always_comb begin
		res_state   = ps_q;
		res_hit     = 1'b0;
		res_here    = '0;
		res_matched = union_q;
		res_visits  = '0;
		res_bytes   = bytes_q;
		case (state_q)
			ST_SCAN_V: begin
				res_state   = nxt_q;
				res_hit     = |acc_rd_q;
				res_here    = acc_rd_q;
				res_matched = union_q | acc_rd_q;
				res_visits  = VW'(vis_new);
				res_bytes   = bytes_inc;
			end
			ST_READ: begin
				res_visits = cur_idx_ok_q ? VW'(vis_rd_q) : '0;
			end
			ST_DONE: begin
				if (cur_kind_q == KIND_START) begin
					res_state   = '0;
					res_matched = '0;
					res_visits  = VW'(1);
					res_bytes   = '0;
				end
			end
			default: begin
				res_state = ps_q;
			end
		endcase
	end

	assign state_w   = SW'(res_state);
	assign here_w    = RW'(res_here);
	assign matched_w = RW'(res_matched);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			clr_one_q   <= 1'b0;
			ps_q        <= '0;
			union_q     <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						case (pop_cmd.kind)
							KIND_SCAN: state_q <= ST_SCAN_T;
							KIND_READ: state_q <= ST_READ;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN_T: begin
					state_q <= ST_SCAN_V;
				end
				ST_SCAN_V: begin
					if (slot_free) begin
						ps_q    <= nxt_q;
						union_q <= union_q | acc_rd_q;
						bytes_q <= bytes_inc;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						if (cur_kind_q == KIND_START) begin
							ps_q       <= '0;
							union_q    <= '0;
							bytes_q    <= '0;
							clr_addr_q <= '0;
							clr_one_q  <= 1'b1;
							state_q    <= ST_CLEAR;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == SB'(STATE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_kind_q   <= pop_cmd.kind;
			cur_idx_ok_q <= pop_cmd.idx_ok;
		end
		if (state_q == ST_SCAN_T) begin
			nxt_q <= nxt_d;
		end
		if (commit) begin
			cur_state_q <= state_w[9:0];
			hit_q       <= res_hit;
			here_q      <= here_w[31:0];
			matched_q   <= matched_w[31:0];
			visits_q    <= res_visits[31:0];
			bytes_out_q <= res_bytes;
		end
	end

	always_ff @(posedge clk) begin
		if (trans_we) begin
			trans_mem[trans_waddr] <= SB'(pop_cmd.target_state);
		end
		if (trans_re) begin
			trans_rd_q <= trans_mem[trans_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[SB'(pop_cmd.state_index)] <= RULE_COUNT'(pop_cmd.rule_mask);
		end
		if (acc_re) begin
			acc_rd_q <= acc_mem[nxt_d];
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		if (vis_re) begin
			vis_rd_q <= vis_mem[vis_raddr];
		end
	end

	assign out_valid     = out_valid_q;
	assign current_state = cur_state_q;
	assign accept_hit    = hit_q;
	assign rules_here    = here_q;
	assign rules_matched = matched_q;
	assign visit_count   = visits_q;
	assign bytes_seen    = bytes_out_q;

`ifndef SYNTHESIS
	a_start_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && cur_kind_q == KIND_START && slot_free) |=>
		(state_q == ST_CLEAR && clr_addr_q == '0 && clr_one_q))
		else $error("start did not enter the counter sweep");

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ps_q) < 32'(STATE_COUNT))
		else $error("present state out of range");

	a_bytes_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_q == '1 && state_q != ST_DONE) |=> bytes_q == '1)
		else $error("byte counter wrapped");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_SCAN_V || $past(state_q) == ST_READ ||
		$past(state_q) == ST_DONE))
		else $error("result raised outside a commit state");
`endif

endmodule

/* hw/rtl/dfa_byte_scanner_with_visit_stats.sv */
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid / in_ready        action, state_index, symbol, target_state, rule_mask
// output    out_valid / out_ready      current_state, accept_hit, rules_here, rules_matched,
//                                      visit_count, bytes_seen
//
// A request passes a one-stage decode and a two-entry queue, then the sequencer runs it:
// loads, starts and unused actions go from idle to a done step, reads to a read step, a scan
// to a transition step and a visit step, whose chain of transition, accept and counter memory
// reads sets the rate. After reset, and after each start request, the visit counters are swept
// one entry per cycle, and no request is accepted meanwhile.
// A stalled output holds the sequencer in its final step while the queue keeps filling.

module dfa_byte_scanner_with_visit_stats import dbs_pkg::*; #(
	parameter int STATE_COUNT = 1024,
	parameter int RULE_COUNT  = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [9:0]  state_index,
	input  logic [7:0]  symbol,
	input  logic [9:0]  target_state,
	input  logic [31:0] rule_mask,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  current_state,
	output logic        accept_hit,
	output logic [31:0] rules_here,
	output logic [31:0] rules_matched,
	output logic [31:0] visit_count,
	output logic [31:0] bytes_seen
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;
	logic clearing;

	dbs_front #(
		.STATE_COUNT(STATE_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.state_index (state_index),
		.symbol      (symbol),
		.target_state(target_state),
		.rule_mask   (rule_mask),
		.clearing    (clearing),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd)
	);

	dbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	dbs_back #(
		.STATE_COUNT(STATE_COUNT),
		.RULE_COUNT (RULE_COUNT),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_cmd      (pop_cmd),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.current_state(current_state),
		.accept_hit   (accept_hit),
		.rules_here   (rules_here),
		.rules_matched(rules_matched),
		.visit_count  (visit_count),
		.bytes_seen   (bytes_seen)
	);

endmodule

/* dv/dbs_scan_checker.sv */
`timescale 1ns / 1ps

module dbs_scan_checker import dbs_pkg::*; #(
	parameter int STATE_COUNT = 1024,
	parameter int RULE_COUNT  = 32,
	parameter int COUNT_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  action,
	input  logic [9:0]  state_index,
	input  logic [7:0]  symbol,
	input  logic [9:0]  target_state,
	input  logic [31:0] rule_mask,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [9:0]  current_state,
	input  logic        accept_hit,
	input  logic [31:0] rules_here,
	input  logic [31:0] rules_matched,
	input  logic [31:0] visit_count,
	input  logic [31:0] bytes_seen,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic [9:0]  state;
		logic        hit;
		logic [31:0] here;
		logic [31:0] matched;
		logic [31:0] visits;
		logic [31:0] nbytes;
	} scan_answer_t;

	localparam logic [31:0] RULE_KEEP = (RULE_COUNT >= 32) ? '1 : ((32'd1 << RULE_COUNT) - 32'd1);

	logic [9:0]            arc_table [0:STATE_COUNT*256-1];
	logic [31:0]           accept_table [0:STATE_COUNT-1];
	logic [COUNT_BITS-1:0] visit_table [0:STATE_COUNT-1] = '{default: '0};
	logic [9:0]            walk_state = '0;
	logic [31:0]           rule_union = '0;
	logic [31:0]           byte_total = '0;
	scan_answer_t          answers_due [$];
	scan_answer_t          oldest;
	int                    fails = 0;

	assign fail_count = fails;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
	endtask

	function automatic scan_answer_t step_automaton(input logic [2:0] act, input logic [9:0] idx,
			input logic [7:0] sym, input logic [9:0] tgt, input logic [31:0] mask);
		scan_answer_t a;
		logic [9:0]   nxt;
		a = '0;
		case (act)
		ACT_LOAD_TRANS: begin
			if (idx < STATE_COUNT && tgt < STATE_COUNT)
				arc_table[int'(idx) * 256 + int'(sym)] = tgt;
		end
		ACT_LOAD_ACCEPT: begin
			if (idx < STATE_COUNT)
				accept_table[idx] = mask & RULE_KEEP;
		end
		ACT_SCAN: begin
			nxt = arc_table[int'(walk_state) * 256 + int'(sym)];
			if (nxt >= STATE_COUNT)
				nxt = '0;
			walk_state = nxt;
			if (visit_table[nxt] != '1)
				visit_table[nxt] = visit_table[nxt] + 1'b1;
			a.here = accept_table[nxt];
			a.hit = (a.here != '0);
			rule_union = rule_union | a.here;
			if (byte_total != '1)
				byte_total = byte_total + 32'd1;
			a.visits = 32'(visit_table[nxt]);
		end
		ACT_READ: begin
			if (idx < STATE_COUNT)
				a.visits = 32'(visit_table[idx]);
		end
		ACT_START: begin
			for (int s = 0; s < STATE_COUNT; s++)
				visit_table[s] = '0;
			visit_table[0] = COUNT_BITS'(1);
			walk_state = '0;
			rule_union = '0;
			byte_total = '0;
			a.visits = 32'd1;
		end
		default: ;
		endcase
		a.state = walk_state;
		a.matched = rule_union;
		a.nbytes = byte_total;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STATE_COUNT; s++)
				visit_table[s] = '0;
			walk_state = '0;
			rule_union = '0;
			byte_total = '0;
			answers_due.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch("result arrived with no request outstanding");
				end else begin
					oldest = answers_due.pop_front();
					check_field("current_state", 32'(current_state), 32'(oldest.state));
					check_field("accept_hit", 32'(accept_hit), 32'(oldest.hit));
					check_field("rules_here", rules_here, oldest.here);
					check_field("rules_matched", rules_matched, oldest.matched);
					check_field("visit_count", visit_count, oldest.visits);
					check_field("bytes_seen", bytes_seen, oldest.nbytes);
				end
			end
			if (in_valid && in_ready)
				answers_due.push_back(step_automaton(action, state_index, symbol, target_state,
					rule_mask));
			pending_count <= answers_due.size();
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	import dbs_pkg::*;

	localparam int QUIET_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 500;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [9:0]  state_index = '0;
	logic [7:0]  symbol = '0;
	logic [9:0]  target_state = '0;
	logic [31:0] rule_mask = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [9:0]  current_state;
	logic        accept_hit;
	logic [31:0] rules_here;
	logic [31:0] rules_matched;
	logic [31:0] visit_count;
	logic [31:0] bytes_seen;
	int          fail_count;
	int          pending_count;
	int          gap_pct = 27;
	int          stall_pct = 79;
	int          quiet_cycles = 0;

	// The request stream keeps its own view of which arcs and accept masks exist, so that
	// a scan only ever follows a written arc into a state whose accept mask is written.
	logic [9:0]  arc_dest [int];
	logic [7:0]  arc_syms [0:1023][$];
	bit          accept_known [0:1023];
	logic [9:0]  accepted_states [$];
	logic [9:0]  hot_states [$];
	logic [9:0]  walk_state = '0;

	always #5 clk = ~clk;

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	dfa_byte_scanner_with_visit_stats u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.state_index  (state_index),
		.symbol       (symbol),
		.target_state (target_state),
		.rule_mask    (rule_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.current_state(current_state),
		.accept_hit   (accept_hit),
		.rules_here   (rules_here),
		.rules_matched(rules_matched),
		.visit_count  (visit_count),
		.bytes_seen   (bytes_seen)
	);

	dbs_scan_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.state_index  (state_index),
		.symbol       (symbol),
		.target_state (target_state),
		.rule_mask    (rule_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.current_state(current_state),
		.accept_hit   (accept_hit),
		.rules_here   (rules_here),
		.rules_matched(rules_matched),
		.visit_count  (visit_count),
		.bytes_seen   (bytes_seen),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	task automatic push_request(input logic [2:0] act, input logic [9:0] idx, input logic [7:0] sym,
			input logic [9:0] tgt, input logic [31:0] mask);
		int key;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		state_index <= idx;
		symbol <= sym;
		target_state <= tgt;
		rule_mask <= mask;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		key = int'(idx) * 256 + int'(sym);
		case (act)
		ACT_LOAD_TRANS: begin
			if (!arc_dest.exists(key))
				arc_syms[idx].push_back(sym);
			arc_dest[key] = tgt;
		end
		ACT_LOAD_ACCEPT: begin
			if (!accept_known[idx]) begin
				accept_known[idx] = 1'b1;
				accepted_states.push_back(idx);
			end
		end
		ACT_SCAN: begin
			walk_state = arc_dest[int'(walk_state) * 256 + int'(sym)];
		end
		ACT_START: begin
			walk_state = '0;
		end
		default: ;
		endcase
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_count != 0);
	endtask

	// Follows a legal arc from the present state, or grows one when no legal arc exists yet.
	task automatic random_scan();
		logic [7:0] legal [$];
		logic [7:0] sym;
		for (int i = 0; i < arc_syms[walk_state].size(); i++) begin
			sym = arc_syms[walk_state][i];
			if (accept_known[arc_dest[int'(walk_state) * 256 + int'(sym)]])
				legal.push_back(sym);
		end
		if (legal.size() > 0)
			push_request(ACT_SCAN, 10'($urandom_range(1023)), legal[$urandom_range(legal.size() - 1)],
				10'($urandom_range(1023)), $urandom);
		else
			push_request(ACT_LOAD_TRANS, walk_state, 8'($urandom_range(255)),
				accepted_states[$urandom_range(accepted_states.size() - 1)], $urandom);
	endtask

	task automatic random_request();
		int          pick;
		logic [9:0]  idx;
		logic [9:0]  tgt;
		logic [31:0] mask;
		pick = $urandom_range(99);
		idx = hot_states[$urandom_range(hot_states.size() - 1)];
		tgt = hot_states[$urandom_range(hot_states.size() - 1)];
		case ($urandom_range(9))
		0: mask = '0;
		1: mask = '1;
		2, 3, 4, 5: mask = 32'd1 << $urandom_range(31);
		default: mask = $urandom & $urandom;
		endcase
		if (pick < 45) begin
			random_scan();
		end else if (pick < 63) begin
			if ($urandom_range(3) != 0)
				idx = walk_state;
			if ($urandom_range(9) == 0)
				tgt = 10'($urandom_range(1023));
			push_request(ACT_LOAD_TRANS, idx, 8'($urandom_range(255)), tgt, $urandom);
		end else if (pick < 73) begin
			if ($urandom_range(9) == 0)
				idx = 10'($urandom_range(1023));
			push_request(ACT_LOAD_ACCEPT, idx, 8'($urandom_range(255)), 10'($urandom_range(1023)),
				mask);
		end else if (pick < 91) begin
			if ($urandom_range(1) == 0)
				idx = 10'($urandom_range(1023));
			push_request(ACT_READ, idx, 8'($urandom_range(255)), 10'($urandom_range(1023)), $urandom);
		end else if (pick < 95) begin
			push_request(ACT_START, 10'($urandom_range(1023)), 8'($urandom_range(255)),
				10'($urandom_range(1023)), $urandom);
		end else begin
			push_request(3'(ACT_START + $urandom_range(1, 3)), 10'($urandom_range(1023)),
				8'($urandom_range(255)), 10'($urandom_range(1023)), $urandom);
		end
	endtask

	initial begin
		hot_states = '{10'd0, 10'd1, 10'd1023};
		repeat (13)
			hot_states.push_back(10'($urandom_range(1022, 2)));
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;

		push_request(ACT_READ, 10'd0, 8'h00, 10'd0, 32'h0);
		push_request(ACT_READ, 10'd1023, 8'hFF, 10'd1023, 32'hFFFF_FFFF);
		push_request(ACT_START, 10'd0, 8'h00, 10'd0, 32'h0);
		push_request(ACT_LOAD_ACCEPT, 10'd0, 8'h00, 10'd0, 32'h0);
		push_request(ACT_LOAD_ACCEPT, 10'd1023, 8'h00, 10'd0, 32'hFFFF_FFFF);
		push_request(ACT_LOAD_ACCEPT, 10'd1, 8'h00, 10'd0, 32'h8000_0001);
		push_request(ACT_LOAD_TRANS, 10'd0, 8'h00, 10'd1023, 32'h0);
		push_request(ACT_LOAD_TRANS, 10'd1023, 8'hFF, 10'd1, 32'h0);
		push_request(ACT_LOAD_TRANS, 10'd1, 8'hA5, 10'd0, 32'h0);
		push_request(ACT_LOAD_TRANS, 10'd0, 8'h5A, 10'd0, 32'h0);
		push_request(ACT_SCAN, 10'd0, 8'h00, 10'd0, 32'h0);
		push_request(ACT_SCAN, 10'd0, 8'hFF, 10'd0, 32'h0);
		push_request(ACT_SCAN, 10'd0, 8'hA5, 10'd0, 32'h0);
		push_request(ACT_SCAN, 10'd0, 8'h5A, 10'd0, 32'h0);
		push_request(ACT_SCAN, 10'd0, 8'h00, 10'd0, 32'h0);
		push_request(ACT_READ, 10'd0, 8'h00, 10'd0, 32'h0);
		push_request(ACT_READ, 10'd1023, 8'h00, 10'd0, 32'h0);
		push_request(ACT_READ, 10'd1, 8'h00, 10'd0, 32'h0);
		for (int k = 1; k <= 3; k++)
			push_request(3'(ACT_START + k), 10'($urandom_range(1023)), 8'($urandom_range(255)),
				10'($urandom_range(1023)), $urandom);
		push_request(ACT_START, 10'd0, 8'h00, 10'd0, 32'h0);
		push_request(ACT_READ, 10'd1023, 8'h00, 10'd0, 32'h0);

		repeat (RANDOM_ITEMS / 3)
			random_request();
		drain_results();
		gap_pct = 79;
		stall_pct = 27;
		repeat (RANDOM_ITEMS / 3)
			random_request();
		drain_results();
		gap_pct = 0;
		stall_pct = 0;
		repeat (RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3))
			random_request();
		drain_results();
		repeat (64)
			@(posedge clk);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
